// ===== rtl/core/vac_pkg.sv =====
// Package for the valve actuator controller core.
// Holds widths, register indexes, reset values, fault bit positions and the
// request, result and configuration structs. No dependencies.
package vac_pkg;

    localparam int TIMER_BITS        = 16;
    localparam int HALF_SECOND_TICKS = 50;
    localparam int CFG_W             = 16;
    localparam int CMP_W             = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
    localparam int CFG_IDX_W         = 3;
    localparam int FAULT_W           = 10;
    localparam int NUM_TIMERS        = 9;
    localparam int TIMER_IDX_W       = 4;

    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TRAVEL_ALARM  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CIRCUIT_CHECK = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NOT_MOVING    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NOT_REACHED   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_BLOCK = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SIM_TRAVEL    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_CIRCUIT_TYPE  = 3'd7;

    localparam logic [CFG_W-1:0] RST_TRAVEL_ALARM  = 16'd1000;
    localparam logic [CFG_W-1:0] RST_CIRCUIT_CHECK = 16'd100;
    localparam logic [CFG_W-1:0] RST_NOT_MOVING    = 16'd300;
    localparam logic [CFG_W-1:0] RST_NOT_REACHED   = 16'd1000;
    localparam logic [CFG_W-1:0] RST_PRESS         = 16'd50;
    localparam logic [CFG_W-1:0] RST_REVERSE_BLOCK = 16'd100;
    localparam logic [CFG_W-1:0] RST_SIM_TRAVEL    = 16'd500;
    localparam logic             RST_CIRCUIT_TYPE  = 1'b0;

    // Local mode command codes; the fourth code changes nothing
    localparam logic [1:0] LM_ENTER = 2'd1;
    localparam logic [1:0] LM_LEAVE = 2'd2;

    // Timer slots
    localparam logic [TIMER_IDX_W-1:0] T_BLK_O = 4'd0;
    localparam logic [TIMER_IDX_W-1:0] T_BLK_C = 4'd1;
    localparam logic [TIMER_IDX_W-1:0] T_MOV_O = 4'd2;
    localparam logic [TIMER_IDX_W-1:0] T_MOV_C = 4'd3;
    localparam logic [TIMER_IDX_W-1:0] T_PRS_O = 4'd4;
    localparam logic [TIMER_IDX_W-1:0] T_PRS_C = 4'd5;
    localparam logic [TIMER_IDX_W-1:0] T_CIR_O = 4'd6;
    localparam logic [TIMER_IDX_W-1:0] T_CIR_C = 4'd7;
    localparam logic [TIMER_IDX_W-1:0] T_SIM   = 4'd8;

    // Fault flag bit positions
    localparam int F_NOMOVE_OPEN  = 0;
    localparam int F_NOMOVE_CLOSE = 1;
    localparam int F_CIRC_OPEN    = 2;
    localparam int F_CIRC_CLOSE   = 3;
    localparam int F_NOT_OPENED   = 4;
    localparam int F_NOT_CLOSED   = 5;
    localparam int F_JAM_OPEN     = 6;
    localparam int F_JAM_CLOSE    = 7;
    localparam int F_SW_CONFLICT  = 8;
    localparam int F_CLUTCH       = 9;

    typedef struct packed {
        logic [CFG_W-1:0] travel_alarm_ticks;
        logic [CFG_W-1:0] circuit_check_ticks;
        logic [CFG_W-1:0] not_moving_ticks;
        logic [CFG_W-1:0] not_reached_ticks;
        logic [CFG_W-1:0] press_ticks;
        logic [CFG_W-1:0] reverse_block_ticks;
        logic [CFG_W-1:0] sim_travel_ticks;
        logic             circuit_type;
    } t_cfg;

    typedef struct packed {
        logic       lim_open;
        logic       lim_closed;
        logic       ctl_open_ok;
        logic       ctl_close_ok;
        logic       clutch_fault;
        logic       auto_open;
        logic       auto_close;
        logic       btn_open;
        logic       btn_close;
        logic [1:0] local_mode_cmd;
        logic       simulate;
        logic       output_ban;
    } t_item;

    typedef struct packed {
        logic               drive_open;
        logic               drive_close;
        logic               remote_ban;
        logic               local_mode;
        logic [FAULT_W-1:0] fault_flags;
        logic               any_fault;
        logic               sim_lim_open;
        logic               sim_lim_closed;
        logic               sim_ctl_open;
        logic               sim_ctl_close;
    } t_result;

    // timer >= limit, compared at a common width
    function automatic logic ticks_ge(input logic [TIMER_BITS-1:0] t,
                                      input logic [CFG_W-1:0] lim);
        ticks_ge = CMP_W'(t) >= CMP_W'(lim);
    endfunction

endpackage

// ===== rtl/core/vac_cfg_regs.sv =====
// Configuration register file of the valve actuator controller.
// Depends on vac_pkg.
module vac_cfg_regs import vac_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr,
    input  logic [CFG_IDX_W-1:0] i_index,
    input  logic [CFG_W-1:0]     i_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr) begin
            case (i_index)
                CFG_TRAVEL_ALARM:  n_cfg.travel_alarm_ticks  = i_data;
                CFG_CIRCUIT_CHECK: n_cfg.circuit_check_ticks = i_data;
                CFG_NOT_MOVING:    n_cfg.not_moving_ticks    = i_data;
                CFG_NOT_REACHED:   n_cfg.not_reached_ticks   = i_data;
                CFG_PRESS:         n_cfg.press_ticks         = i_data;
                CFG_REVERSE_BLOCK: n_cfg.reverse_block_ticks = i_data;
                CFG_SIM_TRAVEL:    n_cfg.sim_travel_ticks    = i_data;
                CFG_CIRCUIT_TYPE:  n_cfg.circuit_type        = i_data[0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.travel_alarm_ticks  <= RST_TRAVEL_ALARM;
            r_cfg.circuit_check_ticks <= RST_CIRCUIT_CHECK;
            r_cfg.not_moving_ticks    <= RST_NOT_MOVING;
            r_cfg.not_reached_ticks   <= RST_NOT_REACHED;
            r_cfg.press_ticks         <= RST_PRESS;
            r_cfg.reverse_block_ticks <= RST_REVERSE_BLOCK;
            r_cfg.sim_travel_ticks    <= RST_SIM_TRAVEL;
            r_cfg.circuit_type        <= RST_CIRCUIT_TYPE;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/vac_timer.sv =====
// Saturating tick timer with limit compare; clears when not running.
// Depends on vac_pkg.
module vac_timer import vac_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_run,
    input  logic [CFG_W-1:0]      i_limit,
    output logic                  o_done,
    output logic [TIMER_BITS-1:0] o_count
);

    logic [TIMER_BITS-1:0] r_cnt;
    logic [TIMER_BITS-1:0] n_cnt;

    always_comb begin
        if (!i_run) begin
            n_cnt  = '0;
            o_done = 1'b0;
        end else if (!ticks_ge(r_cnt, i_limit)) begin
            n_cnt  = (r_cnt == TIMER_MAX) ? r_cnt : r_cnt + TIMER_BITS'(1);
            o_done = 1'b0;
        end else begin
            n_cnt  = r_cnt;
            o_done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_en) begin
            r_cnt <= n_cnt;
        end
    end

    // value after this tick's update
    assign o_count = n_cnt;

endmodule

// ===== rtl/core/vac_step.sv =====
// Per-tick control logic: command latches, timers, drive, faults, simulation.
// Depends on vac_pkg and vac_timer.
module vac_step import vac_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    logic               r_man_open, n_man_open;
    logic               r_auto_open, n_auto_open;
    logic [1:0]         r_prev_auto;
    logic               r_local, n_local;
    logic               r_prev_sim;
    logic               r_drv_o, r_drv_c;
    logic [FAULT_W-1:0] r_fault, n_fault;
    logic               r_jam_o, n_jam_o, r_jam_c, n_jam_c;
    logic               r_sim_lo, r_sim_lc, r_sim_co, r_sim_cc;
    logic               n_sim_lo, n_sim_lc, n_sim_co, n_sim_cc;

    logic                  tm_run  [NUM_TIMERS];
    logic [CFG_W-1:0]      tm_lim  [NUM_TIMERS];
    logic                  tm_en   [NUM_TIMERS];
    logic                  tm_done [NUM_TIMERS];
    logic [TIMER_BITS-1:0] tm_cnt  [NUM_TIMERS];

    logic [1:0] auto_now;
    logic       lo, lc, co, cc, use_sim, open;
    logic       rep_on, rep_of, nm_on, nm_of, n_on, n_of;
    logic       jl_o, jl_c, jam_o, jam_c, do_on, do_of, kv;
    logic       half_gone;

    genvar g;
    generate
        for (g = 0; g < NUM_TIMERS; g++) begin : g_tmr
            vac_timer u_timer (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (tm_en[g]),
                .i_run   (tm_run[g]),
                .i_limit (tm_lim[g]),
                .o_done  (tm_done[g]),
                .o_count (tm_cnt[g])
            );
        end
    endgenerate

    always_comb begin
        use_sim  = i_item.simulate & r_prev_sim;
        lo       = use_sim ? r_sim_lo : i_item.lim_open;
        lc       = use_sim ? r_sim_lc : i_item.lim_closed;
        co       = use_sim ? r_sim_co : i_item.ctl_open_ok;
        cc       = use_sim ? r_sim_cc : i_item.ctl_close_ok;
        auto_now = {i_item.auto_close, i_item.auto_open};

        // local mode: command first, then any auto command change leaves it
        if (i_item.local_mode_cmd == LM_ENTER) begin
            n_local = 1'b1;
        end else if (i_item.local_mode_cmd == LM_LEAVE) begin
            n_local = 1'b0;
        end else begin
            n_local = r_local;
        end
        if (auto_now != r_prev_auto) begin
            n_local = 1'b0;
        end

        if (!r_man_open) begin
            n_man_open = (!n_local & i_item.auto_open) | i_item.btn_open;
        end else begin
            n_man_open = !((!n_local & i_item.auto_close) | i_item.btn_close);
        end
        if (!r_auto_open) begin
            n_auto_open = !n_local & i_item.auto_open;
        end else begin
            n_auto_open = !(!n_local & i_item.auto_close);
        end
        open = n_local ? n_man_open : n_auto_open;

        tm_run[T_BLK_O] = !r_drv_o;
        tm_lim[T_BLK_O] = i_cfg.reverse_block_ticks;
        tm_run[T_BLK_C] = !r_drv_c;
        tm_lim[T_BLK_C] = i_cfg.reverse_block_ticks;
        rep_on = tm_done[T_BLK_O] & i_item.btn_open
               & (r_fault[F_NOT_OPENED] | r_fault[F_NOMOVE_OPEN] | r_fault[F_JAM_OPEN]);
        rep_of = tm_done[T_BLK_C] & i_item.btn_close
               & (r_fault[F_NOT_CLOSED] | r_fault[F_NOMOVE_CLOSE] | r_fault[F_JAM_CLOSE]);

        tm_run[T_MOV_O] = open & !rep_on;
        tm_lim[T_MOV_O] = i_cfg.travel_alarm_ticks;
        tm_run[T_MOV_C] = !open & !rep_of;
        tm_lim[T_MOV_C] = i_cfg.travel_alarm_ticks;

        nm_on = open & lc & ticks_ge(tm_cnt[T_MOV_O], i_cfg.not_moving_ticks);
        nm_of = !open & lo & ticks_ge(tm_cnt[T_MOV_C], i_cfg.not_moving_ticks);
        n_on  = open & !lo & ticks_ge(tm_cnt[T_MOV_O], i_cfg.not_reached_ticks)
              & !r_fault[F_JAM_OPEN];
        n_of  = !open & !lc & ticks_ge(tm_cnt[T_MOV_C], i_cfg.not_reached_ticks)
              & !r_fault[F_JAM_CLOSE];

        tm_run[T_PRS_O] = open & lo;
        tm_lim[T_PRS_O] = i_cfg.press_ticks;
        tm_run[T_PRS_C] = !open & lc;
        tm_lim[T_PRS_C] = i_cfg.press_ticks;

        // jam: limit lost after the press and travel time both ran out
        jl_o    = r_jam_o | (open & tm_done[T_PRS_O] & tm_done[T_MOV_O]);
        jam_o   = open & !lo & jl_o;
        n_jam_o = open & jl_o;
        jl_c    = r_jam_c | (!open & tm_done[T_PRS_C] & tm_done[T_MOV_C]);
        jam_c   = !open & !lc & jl_c;
        n_jam_c = !open & jl_c;

        do_on = open & !tm_done[T_PRS_O] & !tm_done[T_MOV_O] & !i_item.output_ban;
        do_of = !open & !tm_done[T_PRS_C] & !tm_done[T_MOV_C] & !i_item.output_ban;

        kv = lo & lc;

        tm_lim[T_CIR_O] = i_cfg.circuit_check_ticks;
        tm_lim[T_CIR_C] = i_cfg.circuit_check_ticks;
        if (i_cfg.circuit_type) begin
            tm_run[T_CIR_O] = !co;
            tm_run[T_CIR_C] = !cc;
        end else begin
            tm_run[T_CIR_O] = (co & do_on) | (!co & !do_on & !do_of);
            tm_run[T_CIR_C] = (cc & do_of) | (!cc & !do_of & !do_on);
        end

        tm_run[T_SIM] = do_on | do_of;
        tm_lim[T_SIM] = i_cfg.sim_travel_ticks;
        half_gone = CMP_W'(tm_cnt[T_SIM]) >= CMP_W'(HALF_SECOND_TICKS);

        // simulated switches; on entry both limits follow the auto latch
        n_sim_lo = r_prev_sim ? lo : n_auto_open;
        n_sim_lc = r_prev_sim ? lc : !n_auto_open;
        n_sim_co = 1'b1;
        n_sim_cc = 1'b1;
        if (do_on) begin
            if (!i_cfg.circuit_type) begin
                n_sim_co = 1'b0;
            end
            if (half_gone) begin
                n_sim_lc = 1'b0;
            end
            if (tm_done[T_SIM]) begin
                n_sim_lo = 1'b1;
            end
        end
        if (do_of) begin
            if (!i_cfg.circuit_type) begin
                n_sim_cc = 1'b0;
            end
            if (half_gone) begin
                n_sim_lo = 1'b0;
            end
            if (tm_done[T_SIM]) begin
                n_sim_lc = 1'b1;
            end
        end

        for (int k = 0; k < NUM_TIMERS; k++) begin
            tm_en[k] = i_en;
        end
        // the simulation timer holds while not simulating
        tm_en[T_SIM] = i_en & i_item.simulate;

        n_fault = '0;
        n_fault[F_NOMOVE_OPEN]  = nm_on;
        n_fault[F_NOMOVE_CLOSE] = nm_of;
        n_fault[F_CIRC_OPEN]    = tm_done[T_CIR_O];
        n_fault[F_CIRC_CLOSE]   = tm_done[T_CIR_C];
        n_fault[F_NOT_OPENED]   = n_on;
        n_fault[F_NOT_CLOSED]   = n_of;
        n_fault[F_JAM_OPEN]     = jam_o;
        n_fault[F_JAM_CLOSE]    = jam_c;
        n_fault[F_SW_CONFLICT]  = kv;
        n_fault[F_CLUTCH]       = i_item.clutch_fault;

        o_result.drive_open     = do_on;
        o_result.drive_close    = do_of;
        o_result.remote_ban     = i_item.auto_open | i_item.auto_close;
        o_result.local_mode     = n_local;
        o_result.fault_flags    = n_fault;
        o_result.any_fault      = |n_fault;
        o_result.sim_lim_open   = i_item.simulate & n_sim_lo;
        o_result.sim_lim_closed = i_item.simulate & n_sim_lc;
        o_result.sim_ctl_open   = i_item.simulate & n_sim_co;
        o_result.sim_ctl_close  = i_item.simulate & n_sim_cc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_man_open  <= 1'b0;
            r_auto_open <= 1'b0;
            r_prev_auto <= '0;
            r_local     <= 1'b0;
            r_prev_sim  <= 1'b0;
            r_drv_o     <= 1'b0;
            r_drv_c     <= 1'b0;
            r_fault     <= '0;
            r_jam_o     <= 1'b0;
            r_jam_c     <= 1'b0;
            r_sim_lo    <= 1'b0;
            r_sim_lc    <= 1'b0;
            r_sim_co    <= 1'b0;
            r_sim_cc    <= 1'b0;
        end else if (i_en) begin
            r_man_open  <= n_man_open;
            r_auto_open <= n_auto_open;
            r_prev_auto <= auto_now;
            r_local     <= n_local;
            r_prev_sim  <= i_item.simulate;
            r_drv_o     <= do_on;
            r_drv_c     <= do_of;
            r_fault     <= n_fault;
            r_jam_o     <= n_jam_o;
            r_jam_c     <= n_jam_c;
            if (i_item.simulate) begin
                r_sim_lo <= n_sim_lo;
                r_sim_lc <= n_sim_lc;
                r_sim_co <= n_sim_co;
                r_sim_cc <= n_sim_cc;
            end
        end
    end

endmodule

// ===== rtl/core/valve_actuator_controller_core.sv =====
// Valve actuator controller core: one scan tick per request.
// A request passes through the input register, then the result register.
// Throughput: one request per cycle while the result channel does not stall,
// set by the state update in vac_step. Synchronous active-low reset clears
// all timers, latches and flags and loads configuration defaults.
// Depends on vac_pkg, vac_cfg_regs, vac_step.
module valve_actuator_controller_core import vac_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request channel
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_lim_open,
    input  logic                 i_lim_closed,
    input  logic                 i_ctl_open_ok,
    input  logic                 i_ctl_close_ok,
    input  logic                 i_clutch_fault,
    input  logic                 i_auto_open,
    input  logic                 i_auto_close,
    input  logic                 i_btn_open,
    input  logic                 i_btn_close,
    input  logic [1:0]           i_local_mode_cmd,
    input  logic                 i_simulate,
    input  logic                 i_output_ban,
    // result channel
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_drive_open,
    output logic                 o_drive_close,
    output logic                 o_remote_ban,
    output logic                 o_local_mode,
    output logic [FAULT_W-1:0]   o_fault_flags,
    output logic                 o_any_fault,
    output logic                 o_sim_lim_open,
    output logic                 o_sim_lim_closed,
    output logic                 o_sim_ctl_open,
    output logic                 o_sim_ctl_close,
    // configuration write
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_item   r_in;
    logic    r_in_valid;
    t_result r_out;
    logic    r_out_valid;
    t_cfg    cfg;
    t_result step_res;
    logic    advance;
    logic    accept;

    assign o_cfg_ready = 1'b1;

    vac_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid & o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // held request moves into the result register when that one is free
    assign advance = r_in_valid & (!r_out_valid | !i_stall);
    assign o_stall = r_in_valid & !advance;
    assign accept  = i_valid & !o_stall;

    vac_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in.lim_open       <= i_lim_open;
            r_in.lim_closed     <= i_lim_closed;
            r_in.ctl_open_ok    <= i_ctl_open_ok;
            r_in.ctl_close_ok   <= i_ctl_close_ok;
            r_in.clutch_fault   <= i_clutch_fault;
            r_in.auto_open      <= i_auto_open;
            r_in.auto_close     <= i_auto_close;
            r_in.btn_open       <= i_btn_open;
            r_in.btn_close      <= i_btn_close;
            r_in.local_mode_cmd <= i_local_mode_cmd;
            r_in.simulate       <= i_simulate;
            r_in.output_ban     <= i_output_ban;
        end
        if (advance) begin
            r_out <= step_res;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_drive_open     = r_out.drive_open;
    assign o_drive_close    = r_out.drive_close;
    assign o_remote_ban     = r_out.remote_ban;
    assign o_local_mode     = r_out.local_mode;
    assign o_fault_flags    = r_out.fault_flags;
    assign o_any_fault      = r_out.any_fault;
    assign o_sim_lim_open   = r_out.sim_lim_open;
    assign o_sim_lim_closed = r_out.sim_lim_closed;
    assign o_sim_ctl_open   = r_out.sim_ctl_open;
    assign o_sim_ctl_close  = r_out.sim_ctl_close;

endmodule
